### rtl/button_click_classifier_macros.svh
// Assertion macros for the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bcc_pkg.sv
// Types and constants shared by the button click classifier modules.
`default_nettype none
package bcc_pkg;

    localparam int TIME_BITS = 32;
    localparam int LIGHT_BITS = 4;
    localparam int COUNT_BITS = 5;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [TIME_BITS-1:0] LONG_LIMIT_RST = TIME_BITS'(2 * 1000 * 1000);
    localparam logic [TIME_BITS-1:0] SINGLE_TO_RST = TIME_BITS'(500 * 1000);
    localparam logic [TIME_BITS-1:0] DOUBLE_WIN_RST = TIME_BITS'(400 * 1000);
    localparam logic [COUNT_BITS-1:0] MODE_COUNT_RST = COUNT_BITS'(4);

    typedef enum logic [1:0] {
        REG_LONG_LIMIT = 2'd0,
        REG_SINGLE_TO  = 2'd1,
        REG_DOUBLE_WIN = 2'd2,
        REG_MODE_COUNT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_HELD     = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef struct packed {
        logic [TIME_BITS-1:0]  now_us;
        logic                  edge_seen;
        logic [TIME_BITS-1:0]  edge_time_us;
        logic                  settled_level;
        logic [LIGHT_BITS-1:0] light_now;
    } t_req;

    typedef struct packed {
        logic [1:0]            click_event;
        logic                  light_write;
        logic [LIGHT_BITS-1:0] light_next;
        logic                  scan_toggle;
    } t_rsp;

    typedef struct packed {
        logic [TIME_BITS-1:0]  long_limit;
        logic [TIME_BITS-1:0]  single_to;
        logic [TIME_BITS-1:0]  double_win;
        logic [COUNT_BITS-1:0] mode_count;
    } t_cfg;

    typedef struct packed {
        t_phase               phase;
        logic [TIME_BITS-1:0] press_time;
    } t_state;

endpackage
`default_nettype wire

### rtl/bcc_regs.sv
// APB configuration registers of the button click classifier.
`default_nettype none
module bcc_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bcc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [bcc_pkg::DATA_BITS-1:0] pwdata,
    output logic      [bcc_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    output bcc_pkg::t_cfg                      o_cfg
);

    bcc_pkg::t_cfg     r_cfg;
    bcc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = bcc_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_limit <= bcc_pkg::LONG_LIMIT_RST;
            r_cfg.single_to  <= bcc_pkg::SINGLE_TO_RST;
            r_cfg.double_win <= bcc_pkg::DOUBLE_WIN_RST;
            r_cfg.mode_count <= bcc_pkg::MODE_COUNT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                bcc_pkg::REG_LONG_LIMIT: r_cfg.long_limit <= pwdata;
                bcc_pkg::REG_SINGLE_TO:  r_cfg.single_to  <= pwdata;
                bcc_pkg::REG_DOUBLE_WIN: r_cfg.double_win <= pwdata;
                bcc_pkg::REG_MODE_COUNT:
                    r_cfg.mode_count <= pwdata[bcc_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bcc_pkg::REG_LONG_LIMIT: prdata = r_cfg.long_limit;
            bcc_pkg::REG_SINGLE_TO:  prdata = r_cfg.single_to;
            bcc_pkg::REG_DOUBLE_WIN: prdata = r_cfg.double_win;
            bcc_pkg::REG_MODE_COUNT:
                prdata = {{(bcc_pkg::DATA_BITS - bcc_pkg::COUNT_BITS){1'b0}},
                          r_cfg.mode_count};
            default: prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/bcc_classify.sv
// Per-tick classification: timeouts, edge handling, event and next state.
`default_nettype none
module bcc_classify (
    input  wire bcc_pkg::t_cfg   i_cfg,
    input  wire bcc_pkg::t_state i_state,
    input  wire bcc_pkg::t_req   i_req,
    output bcc_pkg::t_state      o_state,
    output bcc_pkg::t_rsp        o_rsp
);

    logic [bcc_pkg::TIME_BITS-1:0]  w_el_now;
    logic [bcc_pkg::TIME_BITS-1:0]  w_el_edge;
    logic                           w_held;
    logic                           w_rel;
    logic                           w_long_to;
    logic                           w_single_to;
    logic                           w_in_p2;
    logic [bcc_pkg::COUNT_BITS-1:0] w_inc;
    bcc_pkg::t_event                w_ev;

    // Modular time differences
    assign w_el_now  = i_req.now_us - i_state.press_time;
    assign w_el_edge = i_req.edge_time_us - i_state.press_time;

    assign w_held      = (i_state.phase == bcc_pkg::PH_HELD);
    assign w_rel       = (i_state.phase == bcc_pkg::PH_RELEASED);
    assign w_long_to   = w_held && (w_el_now > i_cfg.long_limit);
    assign w_single_to = w_rel && (w_el_now > i_cfg.single_to);
    assign w_in_p2     = w_rel && !w_single_to;

    always_comb begin
        o_state = i_state;
        w_ev    = bcc_pkg::EV_NONE;
        if (w_long_to) begin
            w_ev          = bcc_pkg::EV_LONG;
            o_state.phase = bcc_pkg::PH_IDLE;
        end else if (w_single_to) begin
            w_ev          = bcc_pkg::EV_SINGLE;
            o_state.phase = bcc_pkg::PH_IDLE;
        end
        // An edge overrides any timeout event of the same tick
        if (i_req.edge_seen) begin
            if (!i_req.settled_level) begin
                if (w_in_p2) begin
                    if (w_el_edge < i_cfg.double_win) begin
                        w_ev          = bcc_pkg::EV_DOUBLE;
                        o_state.phase = bcc_pkg::PH_IDLE;
                    end
                end else begin
                    w_ev               = bcc_pkg::EV_NONE;
                    o_state.phase      = bcc_pkg::PH_HELD;
                    o_state.press_time = i_req.edge_time_us;
                end
            end else begin
                w_ev          = bcc_pkg::EV_NONE;
                o_state.phase = (w_held && !w_long_to) ? bcc_pkg::PH_RELEASED
                                                       : bcc_pkg::PH_IDLE;
            end
        end
    end

    assign w_inc = {1'b0, i_req.light_now} + bcc_pkg::COUNT_BITS'(1);

    always_comb begin
        o_rsp.click_event = w_ev;
        o_rsp.light_write = (w_ev == bcc_pkg::EV_SINGLE);
        o_rsp.scan_toggle = (w_ev == bcc_pkg::EV_LONG);
        o_rsp.light_next  = '0;
        // Wrap at the mode count or past the last mode
        if (w_ev == bcc_pkg::EV_SINGLE && w_inc < i_cfg.mode_count && !w_inc[4]) begin
            o_rsp.light_next = w_inc[bcc_pkg::LIGHT_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

### rtl/button_click_classifier.sv
// Top level of the button click classifier: request register, state and result register.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  i_req (bcc_pkg::t_req)
//   result    out        o_valid / i_ready  o_rsp (bcc_pkg::t_rsp)
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// One request per cycle is sustained while the result side is not stalled; each request produces exactly one result.
// Each request passes the request register, then classification into the result register.
// The click state updates when a request moves from the request to the result register.
// Reset clears valid flags and click state, not the request and result data registers; no clearing pass.
// A stalled result holds the request register, which frees as soon as the result drains.
`default_nettype none
`include "button_click_classifier_macros.svh"
module button_click_classifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire bcc_pkg::t_req                 i_req,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output bcc_pkg::t_rsp                      o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bcc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [bcc_pkg::DATA_BITS-1:0] pwdata,
    output logic      [bcc_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready
);

    bcc_pkg::t_cfg   w_cfg;
    bcc_pkg::t_state r_state;
    bcc_pkg::t_state n_state;
    bcc_pkg::t_req   r_req;
    bcc_pkg::t_rsp   r_rsp;
    bcc_pkg::t_rsp   n_rsp;
    logic            r_req_vld;
    logic            r_rsp_vld;
    logic            w_move;

    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcc_classify u_classify (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_req   (r_req),
        .o_state (n_state),
        .o_rsp   (n_rsp)
    );

    assign w_move  = r_req_vld && (!r_rsp_vld || i_ready);
    assign o_ready = !r_req_vld || w_move;
    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_state   <= '{phase: bcc_pkg::PH_IDLE, press_time: '0};
        end else begin
            if (o_ready) begin
                r_req_vld <= i_valid;
            end
            if (w_move) begin
                r_rsp_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
        if (w_move) begin
            r_rsp <= n_rsp;
        end
    end

    // Hold the click state unless a request is classified
    `BCC_ASSERT_NEXT(a_state_hold, !w_move, $stable(r_state), "state changed without a request")
    // A pending request is never dropped while the result side stalls
    `BCC_ASSERT_NEXT(a_req_kept, r_req_vld && !w_move, r_req_vld && $stable(r_req), "request lost")
    // Every classified request shows up as a result
    `BCC_ASSERT_NEXT(a_rsp_after_move, w_move, r_rsp_vld, "result missing after classification")

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the button click classifier: timed click gestures, APB setup.
module tb;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    t_req                 i_req = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_rsp                 o_rsp;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    button_click_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    t_req        req_backlog[$];
    t_rsp        click_outcomes_due[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          queued_total = 0;
    int          cycle_count = 0;
    logic [31:0] sim_now = '0;

    // classifier shadow: configuration, phase and press timestamp
    t_cfg                 cfg_model = '{LONG_LIMIT_RST, SINGLE_TO_RST, DOUBLE_WIN_RST, MODE_COUNT_RST};
    t_phase               phase_model = PH_IDLE;
    logic [TIME_BITS-1:0] press_stamp = '0;

    function automatic t_rsp classify_tick(t_req r);
        t_rsp       res;
        t_event     ev;
        logic       second_ok;
        logic       was_held;
        logic [4:0] nxt;
        res = '0;
        ev = EV_NONE;
        second_ok = (phase_model == PH_RELEASED);
        // timeouts come before the edge
        if (phase_model == PH_HELD) begin
            if (r.now_us - press_stamp > cfg_model.long_limit) begin
                ev = EV_LONG;
                phase_model = PH_IDLE;
            end
        end else if (phase_model == PH_RELEASED) begin
            if (r.now_us - press_stamp > cfg_model.single_to) begin
                ev = EV_SINGLE;
                phase_model = PH_IDLE;
                second_ok = 1'b0;
            end
        end
        if (r.edge_seen) begin
            was_held = (phase_model == PH_HELD) && (ev == EV_NONE);
            if (!r.settled_level) begin
                if (second_ok) begin
                    // late second press leaves phase and stamp alone
                    if (r.edge_time_us - press_stamp < cfg_model.double_win) begin
                        ev = EV_DOUBLE;
                        phase_model = PH_IDLE;
                    end
                end else begin
                    ev = EV_NONE;
                    phase_model = PH_HELD;
                    press_stamp = r.edge_time_us;
                end
            end else begin
                ev = EV_NONE;
                phase_model = was_held ? PH_RELEASED : PH_IDLE;
            end
        end
        if (ev == EV_SINGLE) begin
            nxt = {1'b0, r.light_now} + 5'd1;
            if (nxt >= cfg_model.mode_count || nxt > 5'd15)
                nxt = '0;
            res.light_write = 1'b1;
            res.light_next = nxt[3:0];
        end
        res.click_event = ev;
        res.scan_toggle = (ev == EV_LONG);
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                click_outcomes_due.push_back(classify_tick(i_req));
            if (!i_valid || o_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_req <= req_backlog.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (click_outcomes_due.size() == 0) begin
                    $error("unexpected result: click_event %0d", o_rsp.click_event);
                    mismatches++;
                end else begin
                    want = click_outcomes_due.pop_front();
                    if (o_rsp.click_event !== want.click_event) begin
                        $error("click_event: expected %0d, got %0d",
                               want.click_event, o_rsp.click_event);
                        mismatches++;
                    end
                    if (o_rsp.light_write !== want.light_write) begin
                        $error("light_write: expected %0d, got %0d",
                               want.light_write, o_rsp.light_write);
                        mismatches++;
                    end
                    if (o_rsp.light_next !== want.light_next) begin
                        $error("light_next: expected %0d, got %0d",
                               want.light_next, o_rsp.light_next);
                        mismatches++;
                    end
                    if (o_rsp.scan_toggle !== want.scan_toggle) begin
                        $error("scan_toggle: expected %0d, got %0d",
                               want.scan_toggle, o_rsp.scan_toggle);
                        mismatches++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_tick(logic [31:0] now, logic edge_v, logic [31:0] stamp,
                              logic level, logic [3:0] light);
        t_req r;
        r.now_us = now;
        r.edge_seen = edge_v;
        r.edge_time_us = stamp;
        r.settled_level = level;
        r.light_now = light;
        req_backlog.push_back(r);
        queued_total++;
    endtask

    // duration around a limit: exact boundary, one past it, or spread on both sides
    function automatic logic [31:0] near(logic [31:0] lim);
        case ($urandom_range(0, 3))
            0: return lim;
            1: return lim + 32'd1;
            default: return (lim > 32'h3FFF_FFFF) ? $urandom : $urandom_range(0, 2 * lim);
        endcase
    endfunction

    task automatic queue_gesture();
        logic [31:0] t0;
        logic [31:0] hold;
        logic [31:0] gap;
        int          kind;
        t0 = sim_now;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 3))
                queue_tick($urandom, 1'($urandom), $urandom, 1'($urandom), 4'($urandom));
        end else if (kind <= 3) begin
            // hold around the long limit, with or without a tick before the release
            hold = near(cfg_model.long_limit);
            queue_tick(t0 + $urandom_range(0, 40), 1'b1, t0, 1'b0, 4'($urandom));
            if ($urandom_range(0, 9) < 7)
                queue_tick(t0 + hold, 1'b0, $urandom, 1'($urandom), 4'($urandom));
            queue_tick(t0 + hold + $urandom_range(0, 40), 1'b1, t0 + hold, 1'b1,
                       4'($urandom));
            queue_tick(t0 + hold + near(cfg_model.single_to), 1'b0, $urandom, 1'($urandom),
                       4'($urandom));
        end else if (kind <= 6) begin
            // second press around the double window
            gap = near(cfg_model.double_win);
            hold = $urandom_range(0, gap);
            queue_tick(t0 + $urandom_range(0, 40), 1'b1, t0, 1'b0, 4'($urandom));
            queue_tick(t0 + hold + $urandom_range(0, 40), 1'b1, t0 + hold, 1'b1,
                       4'($urandom));
            if ($urandom_range(0, 9) < 3)
                queue_tick(t0 + near(cfg_model.single_to), 1'b0, $urandom, 1'($urandom),
                           4'($urandom));
            queue_tick(t0 + gap + $urandom_range(0, 40), 1'b1, t0 + gap, 1'b0, 4'($urandom));
            queue_tick(t0 + gap + $urandom_range(1, 5000), 1'b1, t0 + gap + 32'd1, 1'b1,
                       4'($urandom));
        end else begin
            // short press, then wait around the single timeout
            hold = $urandom_range(0, cfg_model.single_to);
            queue_tick(t0 + $urandom_range(0, 40), 1'b1, t0, 1'b0, 4'($urandom));
            queue_tick(t0 + hold + $urandom_range(0, 40), 1'b1, t0 + hold, 1'b1,
                       4'($urandom));
            repeat ($urandom_range(1, 2))
                queue_tick(t0 + near(cfg_model.single_to), 1'b0, $urandom, 1'($urandom),
                           4'($urandom));
        end
        sim_now = t0 + near(cfg_model.long_limit) + near(cfg_model.single_to)
                  + $urandom_range(1, 1000);
    endtask

    task automatic run_random(int n_items);
        int target;
        target = queued_total + n_items;
        sim_now = $urandom;
        while (queued_total < target)
            queue_gesture();
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_valid || click_outcomes_due.size() != 0);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LONG_LIMIT: cfg_model.long_limit = val;
            REG_SINGLE_TO:  cfg_model.single_to = val;
            REG_DOUBLE_WIN: cfg_model.double_win = val;
            REG_MODE_COUNT: cfg_model.mode_count = val[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [31:0] lim_long, logic [31:0] lim_single,
                                logic [31:0] win_double, logic [31:0] modes);
        apb_write(REG_LONG_LIMIT, lim_long);
        apb_write(REG_SINGLE_TO, lim_single);
        apb_write(REG_DOUBLE_WIN, win_double);
        apb_write(REG_MODE_COUNT, modes);
        @(negedge i_clk);
    endtask

    initial begin
        // directed requests against the reset configuration
        queue_tick(32'd0, 1'b0, 32'd0, 1'b0, 4'd0);
        queue_tick(32'd150, 1'b1, 32'd100, 1'b0, 4'd5);
        queue_tick(32'd2_000_100, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'd15);
        queue_tick(32'd2_000_101, 1'b0, 32'd0, 1'b0, 4'd2);
        queue_tick(32'd2_100_200, 1'b1, 32'd2_100_150, 1'b1, 4'd0);
        queue_tick(32'd3_000_010, 1'b1, 32'd3_000_000, 1'b0, 4'd0);
        queue_tick(32'd3_100_005, 1'b1, 32'd3_100_000, 1'b1, 4'd0);
        queue_tick(32'd3_500_000, 1'b0, 32'd0, 1'b0, 4'd3);
        queue_tick(32'd3_500_001, 1'b0, 32'd0, 1'b0, 4'd3);
        queue_tick(32'd4_000_000, 1'b1, 32'd4_000_000, 1'b0, 4'd1);
        queue_tick(32'd4_050_000, 1'b1, 32'd4_050_000, 1'b1, 4'd1);
        queue_tick(32'd4_399_999, 1'b1, 32'd4_399_999, 1'b0, 4'd1);
        queue_tick(32'd5_000_000, 1'b1, 32'd5_000_000, 1'b0, 4'd0);
        queue_tick(32'd5_050_000, 1'b1, 32'd5_050_000, 1'b1, 4'd0);
        queue_tick(32'd5_400_000, 1'b1, 32'd5_400_000, 1'b0, 4'd0);
        queue_tick(32'd5_500_001, 1'b0, 32'd0, 1'b0, 4'd1);
        // timeout and edge in the same request: timeout event dropped
        queue_tick(32'd6_000_000, 1'b1, 32'd6_000_000, 1'b0, 4'd0);
        queue_tick(32'd6_010_000, 1'b1, 32'd6_010_000, 1'b1, 4'd0);
        queue_tick(32'd6_600_000, 1'b1, 32'd6_600_000, 1'b0, 4'd2);
        queue_tick(32'd8_600_001, 1'b1, 32'd8_600_001, 1'b1, 4'd0);
        // time wraps during a long press
        queue_tick(32'hFFFF_FF10, 1'b1, 32'hFFFF_FF00, 1'b0, 4'd0);
        queue_tick(32'hFFFF_FF00 + 32'd2_000_001, 1'b0, 32'd0, 1'b0, 4'd0);
        queue_tick(32'd100, 1'b1, 32'd100, 1'b0, 4'd0);
        queue_tick(32'd200, 1'b1, 32'd200, 1'b1, 4'd0);
        queue_tick(32'd600_101, 1'b0, 32'd0, 1'b0, 4'd15);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        program_regs(32'd3000, 32'd800, 32'd500, 32'd16);
        run_random(300);
        wait_drained();

        send_idle_pct = 60;
        program_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
        run_random(300);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 60;
        // upper bits of the mode count are masked off, leaving zero modes
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFE0);
        run_random(300);
        wait_drained();

        send_idle_pct = 25;
        recv_stall_pct = 25;
        program_regs(32'd2_000_000, 32'd500_000, 32'd400_000, 32'h1F);
        run_random(150);
        // hold off new requests until the pipeline drains
        wait_drained();
        run_random(150);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_regs($urandom_range(1, 100_000), $urandom_range(1, 50_000),
                     $urandom_range(1, 60_000), $urandom_range(1, 16));
        run_random(300);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
